// ----- design/puqt_pkg.sv -----
// shared types, constants and request codes of the per-user byte quota table
`timescale 1ns / 1ps

package puqt_pkg;

	// table geometry
	localparam int unsigned USERS  = 1024;
	localparam int unsigned ADDR_W = $clog2(USERS);

	// field widths
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned BYTES_W   = 48;
	localparam int unsigned IP_W      = 32;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned MIB_W     = 28;
	localparam int unsigned MIB_SHIFT = 20;
	localparam int unsigned CFG_IDX_W = 3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PACKET     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_TICK       = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET_LIMITS = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET_BAL    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_DAILY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_CAP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 3'd4;

	// configuration reset values
	localparam logic [BYTES_W-1:0] RST_DEF_START = 48'd7516192768;
	localparam logic [BYTES_W-1:0] RST_DEF_DAILY = 48'd1073741824;
	localparam logic [BYTES_W-1:0] RST_DEF_CAP   = 48'd22548578304;

	// one table entry as stored in memory
	typedef struct packed {
		logic               valid;
		logic [BYTES_W-1:0] start;
		logic [BYTES_W-1:0] daily;
		logic [BYTES_W-1:0] cap;
		logic [BYTES_W-1:0] balance;
	} slot_t;

	localparam int unsigned SLOT_W = $bits(slot_t);

	// one accepted request word
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [IDX_W-1:0] user_index;
		logic             is_ip;
		logic [IP_W-1:0]  src_addr;
		logic [IP_W-1:0]  dst_addr;
		logic [LEN_W-1:0] pkt_len;
		logic [MIB_W-1:0] start_mib;
		logic [MIB_W-1:0] daily_mib;
		logic [MIB_W-1:0] cap_mib;
	} req_t;

	// configured defaults and the internal prefix
	typedef struct packed {
		logic [BYTES_W-1:0] start;
		logic [BYTES_W-1:0] daily;
		logic [BYTES_W-1:0] cap;
		logic [IP_W-1:0]    prefix;
		logic [IP_W-1:0]    mask;
	} dflt_t;

	// result of one slot update
	typedef struct packed {
		slot_t slot;
		logic  charged;
		logic  exhausted;
	} upd_t;

endpackage

// ----- design/puqt_if.sv -----
// request and response channel interfaces of the quota table
`timescale 1ns / 1ps

interface puqt_req_if import puqt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [IDX_W-1:0] user_index;
	logic             is_ip;
	logic [IP_W-1:0]  src_addr;
	logic [IP_W-1:0]  dst_addr;
	logic [LEN_W-1:0] pkt_len;
	logic [MIB_W-1:0] start_mib;
	logic [MIB_W-1:0] daily_mib;
	logic [MIB_W-1:0] cap_mib;

	modport source (
		output valid, req_type, user_index, is_ip, src_addr, dst_addr, pkt_len,
			start_mib, daily_mib, cap_mib,
		input  ready
	);
	modport sink (
		input  valid, req_type, user_index, is_ip, src_addr, dst_addr, pkt_len,
			start_mib, daily_mib, cap_mib,
		output ready
	);
endinterface

interface puqt_rsp_if import puqt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTES_W-1:0] balance_bytes;
	logic [BYTES_W-1:0] start_bytes;
	logic [BYTES_W-1:0] daily_bytes;
	logic [BYTES_W-1:0] cap_bytes;
	logic               charged;
	logic               exhausted;

	modport source (
		output valid, balance_bytes, start_bytes, daily_bytes, cap_bytes, charged,
			exhausted,
		input  ready
	);
	modport sink (
		input  valid, balance_bytes, start_bytes, daily_bytes, cap_bytes, charged,
			exhausted,
		output ready
	);
endinterface

// ----- design/puqt_ram.sv -----
// generic single-port-write, registered-read memory
`timescale 1ns / 1ps

module puqt_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/puqt_update.sv -----
// slot update: set-up of new slots, packet charge, limit and balance writes and daily refill
`timescale 1ns / 1ps

module puqt_update import puqt_pkg::*; (
	input  req_t  req,
	input  slot_t cur,
	input  dflt_t dflt,
	output upd_t  upd
);

	slot_t              base;
	slot_t              nxt;
	logic               src_int;
	logic               dst_int;
	logic [BYTES_W-1:0] len_w;
	logic [BYTES_W-1:0] bal_chg;
	logic [BYTES_W:0]   refill_sum;
	logic               chg;
	logic               exh;

	// internal address match under the mask
	assign src_int = ((req.src_addr ^ dflt.prefix) & dflt.mask) == '0;
	assign dst_int = ((req.dst_addr ^ dflt.prefix) & dflt.mask) == '0;

	// a slot first touched by a packet, limit, balance or read request starts from the defaults
	always_comb begin
		base = cur;
		if (!cur.valid) begin
			base.valid   = 1'b1;
			base.start   = dflt.start;
			base.daily   = dflt.daily;
			base.cap     = dflt.cap;
			base.balance = dflt.start;
		end
	end

	// saturating charge and daily refill
	assign len_w      = BYTES_W'(req.pkt_len);
	assign bal_chg    = (base.balance >= len_w) ? (base.balance - len_w) : '0;
	assign refill_sum = {1'b0, cur.balance} + {1'b0, cur.daily};

	// per request kind
	always_comb begin
		nxt = base;
		chg = 1'b0;
		exh = 1'b0;
		unique case (req.req_type)
			REQ_PACKET: begin
				if (req.is_ip && !(src_int && dst_int)) begin
					nxt.balance = bal_chg;
					chg         = 1'b1;
					exh         = (base.start != '0) && (bal_chg == '0);
				end
			end
			REQ_TICK: begin
				nxt = cur;
				if (cur.valid) begin
					nxt.balance = (refill_sum > {1'b0, cur.cap}) ? cur.cap
						: refill_sum[BYTES_W-1:0];
				end
			end
			REQ_SET_LIMITS: begin
				nxt.start = {req.start_mib, MIB_SHIFT'(0)};
				nxt.daily = {req.daily_mib, MIB_SHIFT'(0)};
				nxt.cap   = {req.cap_mib, MIB_SHIFT'(0)};
			end
			REQ_SET_BAL: begin
				nxt.balance = {req.start_mib, MIB_SHIFT'(0)};
			end
			REQ_READ: begin
				nxt = base;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign upd.slot      = nxt;
	assign upd.charged   = chg;
	assign upd.exhausted = exh;

endmodule

// ----- design/per_user_byte_quota_table_top.sv -----
// top level of the per-user byte quota table: control, config registers, result register
`timescale 1ns / 1ps

// Per-user byte quota table. Requests arrive as words on the req channel
// (valid/ready), one result word per request leaves on the rsp channel.
// Slot state lives in one memory of USERS entries with a registered read.
// Packet, set limits, set balance and read requests are a read-modify-write
// of one entry: the word is taken and the entry read, then the entry is
// updated and the result register loaded once the result register is free.
// A day tick walks the whole memory through one read and one write per
// cycle and then loads an all-zero result before the next word is taken.
// Unused request codes produce an all-zero result.
// After reset the block sweeps the memory once to clear the valid bits,
// with req.ready low during the sweep; config writes are taken at any
// time through cfg_we/cfg_index/cfg_data.
// The result register holds its word while rsp.ready is low; a finished
// update waits for it and the block takes no new word in that time.

module per_user_byte_quota_table_top import puqt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTES_W-1:0]   cfg_data,
	puqt_req_if.sink             req,
	puqt_rsp_if.source           rsp
);

	// control states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RMW   = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(USERS - 1);

	logic [2:0]         state_q;
	logic [2:0]         state_d;
	logic [ADDR_W-1:0]  walk_q;
	logic [ADDR_W-1:0]  walk_d;
	req_t               req_q;
	req_t               req_in;
	dflt_t              dflt_q;
	logic               accept;
	logic               out_free;
	logic               idx_ok;
	logic               ram_we;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ADDR_W-1:0]  ram_raddr;
	slot_t              ram_wdata;
	logic [SLOT_W-1:0]  ram_rdata;
	slot_t              cur_slot;
	req_t               upd_req;
	upd_t               upd;
	logic               rsp_load;
	logic               rsp_zero;
	logic               rsp_valid_q;
	logic [BYTES_W-1:0] rsp_bal_q;
	logic [BYTES_W-1:0] rsp_start_q;
	logic [BYTES_W-1:0] rsp_daily_q;
	logic [BYTES_W-1:0] rsp_cap_q;
	logic               rsp_chg_q;
	logic               rsp_exh_q;

	// incoming word
	assign req_in.req_type   = req.req_type;
	assign req_in.user_index = req.user_index;
	assign req_in.is_ip      = req.is_ip;
	assign req_in.src_addr   = req.src_addr;
	assign req_in.dst_addr   = req.dst_addr;
	assign req_in.pkt_len    = req.pkt_len;
	assign req_in.start_mib  = req.start_mib;
	assign req_in.daily_mib  = req.daily_mib;
	assign req_in.cap_mib    = req.cap_mib;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign idx_ok    = 32'(req.user_index) < USERS;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q.start  <= RST_DEF_START;
			dflt_q.daily  <= RST_DEF_DAILY;
			dflt_q.cap    <= RST_DEF_CAP;
			dflt_q.prefix <= '0;
			dflt_q.mask   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEF_START: dflt_q.start  <= cfg_data;
				CFG_DEF_DAILY: dflt_q.daily  <= cfg_data;
				CFG_DEF_CAP:   dflt_q.cap    <= cfg_data;
				CFG_PREFIX:    dflt_q.prefix <= cfg_data[IP_W-1:0];
				CFG_MASK:      dflt_q.mask   <= cfg_data[IP_W-1:0];
				default:       dflt_q.start  <= dflt_q.start;
			endcase
		end
	end

	// slot memory
	puqt_ram #(
		.DEPTH (USERS),
		.WIDTH (SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cur_slot = slot_t'(ram_rdata);

	// the walk always applies the refill
	always_comb begin
		upd_req = req_q;
		if (state_q == ST_WALK) begin
			upd_req.req_type = REQ_TICK;
		end
	end

	puqt_update u_update (
		.req  (upd_req),
		.cur  (cur_slot),
		.dflt (dflt_q),
		.upd  (upd)
	);

	// sequencer: clear sweep, read-modify-write, refill walk
	always_comb begin
		state_d   = state_q;
		walk_d    = walk_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = walk_q;
		ram_raddr = ADDR_W'(req.user_index);
		ram_wdata = upd.slot;
		rsp_load  = 1'b0;
		rsp_zero  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				walk_d    = walk_q + ADDR_W'(1);
				if (walk_q == LAST_ADDR) begin
					walk_d  = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_TICK) begin
						ram_re    = 1'b1;
						ram_raddr = '0;
						state_d   = ST_WALK;
					end else if (req.req_type <= REQ_READ && idx_ok) begin
						ram_re  = 1'b1;
						state_d = ST_RMW;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_RMW: begin
				ram_waddr = ADDR_W'(req_q.user_index);
				if (out_free) begin
					ram_we   = 1'b1;
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_WALK: begin
				ram_we    = 1'b1;
				ram_raddr = walk_q + ADDR_W'(1);
				walk_d    = walk_q + ADDR_W'(1);
				if (walk_q == LAST_ADDR) begin
					walk_d  = '0;
					state_d = ST_DONE;
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rsp_zero = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
				walk_d  = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
		end
	end

	// accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			if (rsp_zero) begin
				rsp_bal_q   <= '0;
				rsp_start_q <= '0;
				rsp_daily_q <= '0;
				rsp_cap_q   <= '0;
				rsp_chg_q   <= 1'b0;
				rsp_exh_q   <= 1'b0;
			end else begin
				rsp_bal_q   <= upd.slot.balance;
				rsp_start_q <= upd.slot.start;
				rsp_daily_q <= upd.slot.daily;
				rsp_cap_q   <= upd.slot.cap;
				rsp_chg_q   <= upd.charged;
				rsp_exh_q   <= upd.exhausted;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.balance_bytes = rsp_bal_q;
	assign rsp.start_bytes   = rsp_start_q;
	assign rsp.daily_bytes   = rsp_daily_q;
	assign rsp.cap_bytes     = rsp_cap_q;
	assign rsp.charged       = rsp_chg_q;
	assign rsp.exhausted     = rsp_exh_q;

	// a write and a read of the same entry never meet in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("slot memory read and write hit the same entry");

	// the walk pointer rests at zero between walks
	a_walk_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (walk_q == '0))
		else $error("walk pointer not at zero while idle");

	// a request update always leaves the slot set up
	a_rmw_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW && ram_we) |-> ram_wdata.valid)
		else $error("updated slot written back without valid mark");

	// exhausted is only reported with a charge
	a_exh_charged: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_exh_q) |-> rsp_chg_q)
		else $error("exhausted reported without a charge");

	// a day tick starts the walk of the table at slot zero
	a_tick_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_TICK) |=> (state_q == ST_WALK && walk_q == '0))
		else $error("day tick did not start the walk at slot zero");

endmodule
